// ----- hw/rtl/mpfw_pkg.sv -----
// ----------------------------------------------------------------------------
// mpfw_pkg
// Shared types and constants for the multi-port freshness watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

package mpfw_pkg;

  localparam int NUM_PORTS   = 8;
  localparam int MAX_RESULTS = 8;

  localparam int ACT_W  = 2;
  localparam int PORT_W = 3;
  localparam int TIME_W = 64;
  localparam int KIND_W = 2;

  // table index, sweep counter, result buffer index and count
  localparam int PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int ICNT_W = $clog2(NUM_PORTS + 1);
  localparam int RIDX_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int RCNT_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_ENROLL = 2'd0,
    ACT_ARRIVE = 2'd1,
    ACT_CHECK  = 2'd2,
    ACT_RSVD   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_UNINIT  = 2'd0,
    ST_FRESH   = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_e;

  typedef enum logic [KIND_W-1:0] {
    EV_NONE       = 2'd0,
    EV_FRESH      = 2'd1,
    EV_TIMEOUT    = 2'd2,
    EV_UNENROLLED = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DECODE = 3'd1,
    S_RUN    = 3'd2,
    S_FINISH = 3'd3,
    S_EMIT   = 3'd4
  } state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/mpfw_ram.sv -----
// ----------------------------------------------------------------------------
// mpfw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       wr_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]                           wr_data_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output      logic [WIDTH-1:0]                           rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/multi_port_freshness_watchdog.sv -----
// ----------------------------------------------------------------------------
// multi_port_freshness_watchdog
// Flow: an accepted item passes DECODE, RUN (arrival and check-all only), FINISH
//   and EMIT; results then leave one per cycle while out_stall_i is low.
// Throughput: one item at a time; the next item is taken the cycle after its
//   last result is taken. Check-all is bound by the single read port of the
//   time and period RAMs, one port visited per cycle.
// Reset: no port enrolled, all status uninitialized; RAMs need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_port_freshness_watchdog (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input items
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic [mpfw_pkg::ACT_W-1:0]      action_i,
  input  wire logic [mpfw_pkg::PORT_W-1:0]     port_index_i,
  input  wire logic [mpfw_pkg::TIME_W-1:0]     period_ns_i,
  input  wire logic [mpfw_pkg::TIME_W-1:0]     time_ns_i,
  // result items
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic [mpfw_pkg::KIND_W-1:0]     event_kind_o,
  output      logic [mpfw_pkg::PORT_W-1:0]     event_port_o,
  output      logic [mpfw_pkg::TIME_W-1:0]     event_time_ns_o,
  output      logic                            all_ready_o,
  output      logic                            last_of_run_o
);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  mpfw_pkg::state_e  state_q, state_d;

  // latched item
  mpfw_pkg::action_e              act_q;
  logic [mpfw_pkg::PORT_W-1:0]    port_q;
  logic [mpfw_pkg::TIME_W-1:0]    period_q;
  logic [mpfw_pkg::TIME_W-1:0]    time_q;

  // per-port flags live in flops (they have a defined reset)
  logic                           enrolled_q [mpfw_pkg::NUM_PORTS];
  mpfw_pkg::status_e              status_q   [mpfw_pkg::NUM_PORTS];

  // read/evaluate pipeline: issue -> s1 (RAM data) -> s2 (compare, update)
  logic [mpfw_pkg::ICNT_W-1:0]    iss_cnt_q;
  logic                           s1_vld_q;
  logic [mpfw_pkg::PIDX_W-1:0]    s1_idx_q;
  logic                           s2_vld_q;
  logic [mpfw_pkg::PIDX_W-1:0]    s2_idx_q;
  logic [mpfw_pkg::TIME_W-1:0]    dt_q;
  logic [mpfw_pkg::TIME_W-1:0]    per_q;

  // result buffer; all_ready is only known once the item is fully applied
  mpfw_pkg::event_e               res_kind_q [mpfw_pkg::MAX_RESULTS];
  logic [mpfw_pkg::PORT_W-1:0]    res_port_q [mpfw_pkg::MAX_RESULTS];
  logic [mpfw_pkg::RCNT_W-1:0]    res_cnt_q;
  logic [mpfw_pkg::RIDX_W-1:0]    rd_q;
  logic                           ready_q;

  // --------------------------------------------------------------------------
  // Decode helpers
  // --------------------------------------------------------------------------
  logic [mpfw_pkg::PIDX_W-1:0]    pidx;
  logic                           port_ok;
  logic                           arr_ok;
  logic [mpfw_pkg::ICNT_W-1:0]    iss_num;
  logic                           issuing;
  logic [mpfw_pkg::PIDX_W-1:0]    rd_addr;
  logic                           last_res;

  assign pidx    = mpfw_pkg::PIDX_W'(port_q);
  assign port_ok = (32'(port_q) < mpfw_pkg::NUM_PORTS);
  assign arr_ok  = port_ok && enrolled_q[pidx];

  // arrival reads its own port once; check-all sweeps every port
  assign iss_num = (act_q == mpfw_pkg::ACT_ARRIVE) ? mpfw_pkg::ICNT_W'(1)
                                                   : mpfw_pkg::ICNT_W'(mpfw_pkg::NUM_PORTS);
  assign issuing = (state_q == mpfw_pkg::S_RUN) && (iss_cnt_q < iss_num);
  assign rd_addr = (act_q == mpfw_pkg::ACT_ARRIVE) ? pidx
                                                   : mpfw_pkg::PIDX_W'(iss_cnt_q);

  assign last_res = (mpfw_pkg::RCNT_W'(rd_q) + mpfw_pkg::RCNT_W'(1)) == res_cnt_q;

  // --------------------------------------------------------------------------
  // Time and period RAMs
  // --------------------------------------------------------------------------
  logic                           per_we;
  logic                           time_we;
  logic [mpfw_pkg::TIME_W-1:0]    per_rd;
  logic [mpfw_pkg::TIME_W-1:0]    time_rd;

  mpfw_ram #(
    .WIDTH (mpfw_pkg::TIME_W),
    .DEPTH (mpfw_pkg::NUM_PORTS)
  ) u_period_ram (
    .clk_i     (clk_i),
    .wr_en_i   (per_we),
    .wr_addr_i (pidx),
    .wr_data_i (period_q),
    .rd_addr_i (rd_addr),
    .rd_data_o (per_rd)
  );

  mpfw_ram #(
    .WIDTH (mpfw_pkg::TIME_W),
    .DEPTH (mpfw_pkg::NUM_PORTS)
  ) u_time_ram (
    .clk_i     (clk_i),
    .wr_en_i   (time_we),
    .wr_addr_i (s2_idx_q),
    .wr_data_i (time_q),
    .rd_addr_i (rd_addr),
    .rd_data_o (time_rd)
  );

  // elapsed time, clamped at zero when the stored time is later
  logic [mpfw_pkg::TIME_W-1:0]    dt_d;
  assign dt_d = (time_rd > time_q) ? '0 : (time_q - time_rd);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mpfw_pkg::S_IDLE: begin
        if (in_valid_i) state_d = mpfw_pkg::S_DECODE;
      end
      mpfw_pkg::S_DECODE: begin
        if ((act_q == mpfw_pkg::ACT_ARRIVE && arr_ok) || act_q == mpfw_pkg::ACT_CHECK) begin
          state_d = mpfw_pkg::S_RUN;
        end else begin
          state_d = mpfw_pkg::S_FINISH;
        end
      end
      mpfw_pkg::S_RUN: begin
        // s2 finishes on this edge, FINISH sees its status and push
        if (!issuing && !s1_vld_q) state_d = mpfw_pkg::S_FINISH;
      end
      mpfw_pkg::S_FINISH: begin
        state_d = mpfw_pkg::S_EMIT;
      end
      mpfw_pkg::S_EMIT: begin
        if (!out_stall_i && last_res) state_d = mpfw_pkg::S_IDLE;
      end
      default: state_d = mpfw_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control outputs: handshake, RAM writes, status update and result push
  // --------------------------------------------------------------------------
  logic                           st_we;
  mpfw_pkg::status_e              st_new;
  logic                           push_en;
  mpfw_pkg::event_e               push_kind;
  logic [mpfw_pkg::PORT_W-1:0]    push_port;
  logic                           push_ok;
  logic                           ge;
  logic                           all_fresh;

  assign ge = (dt_q >= per_q);

  always_comb begin
    in_stall_o  = (state_q != mpfw_pkg::S_IDLE);
    out_valid_o = (state_q == mpfw_pkg::S_EMIT);
    per_we      = (state_q == mpfw_pkg::S_DECODE) && (act_q == mpfw_pkg::ACT_ENROLL) &&
                  port_ok && !enrolled_q[pidx];
    time_we     = s2_vld_q && (act_q == mpfw_pkg::ACT_ARRIVE);
    st_we       = 1'b0;
    st_new      = mpfw_pkg::ST_UNINIT;
    push_en     = 1'b0;
    push_kind   = mpfw_pkg::EV_NONE;
    push_port   = '0;
    unique case (state_q)
      mpfw_pkg::S_DECODE: begin
        if (act_q == mpfw_pkg::ACT_ARRIVE && !arr_ok) begin
          push_en   = 1'b1;
          push_kind = mpfw_pkg::EV_UNENROLLED;
          push_port = port_q;
        end
      end
      mpfw_pkg::S_RUN: begin
        if (s2_vld_q && enrolled_q[s2_idx_q]) begin
          unique case (status_q[s2_idx_q])
            mpfw_pkg::ST_FRESH: begin
              if (ge) begin
                st_we     = 1'b1;
                st_new    = mpfw_pkg::ST_TIMEOUT;
                push_en   = 1'b1;
                push_kind = mpfw_pkg::EV_TIMEOUT;
              end
            end
            mpfw_pkg::ST_TIMEOUT: begin
              if (!ge) begin
                st_we     = 1'b1;
                st_new    = mpfw_pkg::ST_FRESH;
                push_en   = 1'b1;
                push_kind = mpfw_pkg::EV_FRESH;
              end
            end
            mpfw_pkg::ST_UNINIT: begin
              // first arrival; a sweep leaves it alone
              if (act_q == mpfw_pkg::ACT_ARRIVE) begin
                st_we     = 1'b1;
                st_new    = mpfw_pkg::ST_FRESH;
                push_en   = 1'b1;
                push_kind = mpfw_pkg::EV_FRESH;
              end
            end
            default: ;
          endcase
          push_port = mpfw_pkg::PORT_W'(s2_idx_q);
        end
      end
      mpfw_pkg::S_FINISH: begin
        if (res_cnt_q == '0) begin
          push_en   = 1'b1;
          push_kind = mpfw_pkg::EV_NONE;
        end
      end
      default: ;
    endcase
    push_ok = push_en && (res_cnt_q < mpfw_pkg::RCNT_W'(mpfw_pkg::MAX_RESULTS));
  end

  always_comb begin
    all_fresh = 1'b1;
    for (int p = 0; p < mpfw_pkg::NUM_PORTS; p++) begin
      if (enrolled_q[p] && status_q[p] != mpfw_pkg::ST_FRESH) all_fresh = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mpfw_pkg::S_IDLE;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      iss_cnt_q <= '0;
      res_cnt_q <= '0;
      rd_q      <= '0;
      for (int p = 0; p < mpfw_pkg::NUM_PORTS; p++) begin
        enrolled_q[p] <= 1'b0;
        status_q[p]   <= mpfw_pkg::ST_UNINIT;
      end
    end else begin
      state_q  <= state_d;
      s1_vld_q <= issuing;
      s2_vld_q <= s1_vld_q;

      if (state_q == mpfw_pkg::S_IDLE && in_valid_i) begin
        res_cnt_q <= '0;
        rd_q      <= '0;
      end else if (push_ok) begin
        res_cnt_q <= res_cnt_q + mpfw_pkg::RCNT_W'(1);
      end

      if (state_q == mpfw_pkg::S_DECODE) begin
        iss_cnt_q <= '0;
      end else if (issuing) begin
        iss_cnt_q <= iss_cnt_q + mpfw_pkg::ICNT_W'(1);
      end

      if (per_we) begin
        enrolled_q[pidx] <= 1'b1;
        status_q[pidx]   <= mpfw_pkg::ST_UNINIT;
      end
      if (st_we) status_q[s2_idx_q] <= st_new;

      if (out_valid_o && !out_stall_i && !last_res) begin
        rd_q <= rd_q + mpfw_pkg::RIDX_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (state_q == mpfw_pkg::S_IDLE && in_valid_i) begin
      act_q    <= mpfw_pkg::action_e'(action_i);
      port_q   <= port_index_i;
      period_q <= period_ns_i;
      time_q   <= time_ns_i;
    end
    s1_idx_q <= rd_addr;
    s2_idx_q <= s1_idx_q;
    dt_q     <= dt_d;
    per_q    <= per_rd;
    if (push_ok) begin
      res_kind_q[res_cnt_q[mpfw_pkg::RIDX_W-1:0]] <= push_kind;
      res_port_q[res_cnt_q[mpfw_pkg::RIDX_W-1:0]] <= push_port;
    end
    if (state_q == mpfw_pkg::S_FINISH) ready_q <= all_fresh;
  end

  // --------------------------------------------------------------------------
  // Result port
  // --------------------------------------------------------------------------
  assign event_kind_o    = res_kind_q[rd_q];
  assign event_port_o    = res_port_q[rd_q];
  // enroll and the reserved action report a zero time
  assign event_time_ns_o = (act_q == mpfw_pkg::ACT_ENROLL || act_q == mpfw_pkg::ACT_RSVD)
                           ? '0 : time_q;
  assign all_ready_o     = ready_q;
  assign last_of_run_o   = last_res;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (res_cnt_q != '0))
    else $error("result shown from an empty buffer");

  a_pipe_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q || s2_vld_q) |-> (state_q == mpfw_pkg::S_RUN))
    else $error("evaluation pipeline busy outside the run state");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_of_run_o) |=> (state_q == mpfw_pkg::S_IDLE))
    else $error("no return to idle after the final result");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_cnt_q <= mpfw_pkg::ICNT_W'(mpfw_pkg::NUM_PORTS))
    else $error("sweep counter ran past the port table");

endmodule

`default_nettype wire
